[hdl/touch_slot_event_classifier_assert.svh]
// ----------------------------------------------------------------------------
// touch slot event classifier assertion macros
// shared property forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef TOUCH_SLOT_EVENT_CLASSIFIER_ASSERT_SVH
`define TOUCH_SLOT_EVENT_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSEC_ASSERT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("tsec assertion failed");

// next-cycle implication, disabled in reset
`define TSEC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("tsec assertion failed");

`endif

[hdl/tsec_pkg.sv]
// ----------------------------------------------------------------------------
// tsec_pkg
// shared types, constants and codes of the touch slot event classifier
// ----------------------------------------------------------------------------
package tsec_pkg;

	// number of touch slots tracked
	localparam int SLOTS = 5;
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// decoupling queue between front and back, power of two
	localparam int MIDQ_DEPTH = 4;
	localparam int MIDQ_PTR_W = $clog2(MIDQ_DEPTH);
	localparam int MIDQ_CNT_W = MIDQ_PTR_W + 1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd5;

	// register reset values
	localparam logic [15:0] MAX_X_RST      = 16'd800;
	localparam logic [15:0] MAX_Y_RST      = 16'd480;
	localparam logic [3:0]  DOWN_TICKS_RST = 4'd2;
	localparam logic [4:0]  HOLD_TICKS_RST = 5'd20;

	// saturation level of the tick counter
	localparam logic [4:0] TICK_MAX = 5'd31;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_DOWN = 3'd1,
		EV_MOVE = 3'd2,
		EV_HOLD = 3'd3,
		EV_UP   = 3'd4
	} event_t;

	typedef struct packed {
		logic [15:0] max_x;
		logic [15:0] max_y;
		logic        mirror_x;
		logic        mirror_y;
		logic [3:0]  down_ticks;
		logic [4:0]  hold_ticks;
	} cfg_t;

	// classified poll, front to back
	typedef struct packed {
		logic [2:0]            slot;
		logic                  slot_ok;
		logic [SLOT_IDX_W-1:0] slot_idx;
		logic                  touch;
		logic [15:0]           x;
		logic [15:0]           y;
	} front_word_t;

	// result word
	typedef struct packed {
		logic [2:0]  slot;
		event_t      ev;
		logic [15:0] x;
		logic [15:0] y;
	} res_t;

endpackage

[hdl/tsec_front.sv]
// ----------------------------------------------------------------------------
// tsec_front
// mirrors coordinates and classifies a poll as touch or no touch
// ----------------------------------------------------------------------------
module tsec_front (
	input  tsec_pkg::cfg_t      cfg,
	input  logic [2:0]          slot,
	input  logic                present,
	input  logic [15:0]         raw_x,
	input  logic [15:0]         raw_y,
	output tsec_pkg::front_word_t word
);

	logic [15:0] x_m;
	logic [15:0] y_m;
	logic        slot_ok;

	// mirror wraps at 16 bits
	assign x_m = cfg.mirror_x ? (cfg.max_x - 16'd1 - raw_x) : raw_x;
	assign y_m = cfg.mirror_y ? (cfg.max_y - 16'd1 - raw_y) : raw_y;

	assign slot_ok = (int'(slot) < tsec_pkg::SLOTS);

	always_comb begin
		word.slot     = slot;
		word.slot_ok  = slot_ok;
		word.slot_idx = slot_ok ? tsec_pkg::SLOT_IDX_W'(slot) : '0;
		word.touch    = present && (x_m < cfg.max_x) && (y_m < cfg.max_y);
		word.x        = x_m;
		word.y        = y_m;
	end

endmodule

[hdl/tsec_fifo.sv]
// ----------------------------------------------------------------------------
// tsec_fifo
// small register queue decoupling the front from the back
// ----------------------------------------------------------------------------
`include "touch_slot_event_classifier_assert.svh"

module tsec_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tsec_pkg::front_word_t wdata,
	output logic                  full,
	input  logic                  pop,
	output tsec_pkg::front_word_t rdata,
	output logic                  empty
);

	tsec_pkg::front_word_t             mem_q [tsec_pkg::MIDQ_DEPTH];
	logic [tsec_pkg::MIDQ_PTR_W-1:0]   wr_ptr_q;
	logic [tsec_pkg::MIDQ_PTR_W-1:0]   rd_ptr_q;
	logic [tsec_pkg::MIDQ_CNT_W-1:0]   cnt_q;
	logic                              wr_en;
	logic                              rd_en;

	assign full  = (cnt_q == tsec_pkg::MIDQ_CNT_W'(tsec_pkg::MIDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`TSEC_ASSERT(a_cnt_in_range, clk, arst_n, 1'b1, cnt_q <= tsec_pkg::MIDQ_CNT_W'(tsec_pkg::MIDQ_DEPTH))
	`TSEC_ASSERT_NEXT(a_full_holds, clk, arst_n, full && !pop, full)
	`TSEC_ASSERT_NEXT(a_empty_holds, clk, arst_n, empty && !push, empty)

endmodule

[hdl/tsec_back.sv]
// ----------------------------------------------------------------------------
// tsec_back
// per-slot tick counters and latched positions, event decision, result buffer
// ----------------------------------------------------------------------------
`include "touch_slot_event_classifier_assert.svh"

module tsec_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsec_pkg::cfg_t        cfg,
	input  logic                  in_empty,
	input  tsec_pkg::front_word_t in_word,
	output logic                  in_pop,
	output logic                  res_empty,
	input  logic                  res_pop,
	output tsec_pkg::res_t        res
);

	logic [4:0]       tick_q [tsec_pkg::SLOTS];
	logic [15:0]      lx_q   [tsec_pkg::SLOTS];
	logic [15:0]      ly_q   [tsec_pkg::SLOTS];

	tsec_pkg::res_t   out_mem_q [2];
	logic             out_wr_q;
	logic             out_rd_q;
	logic [1:0]       out_cnt_q;
	logic             out_full;
	logic             out_rd_en;

	logic [4:0]       tick_nx;
	logic [15:0]      lx_nx;
	logic [15:0]      ly_nx;
	tsec_pkg::res_t   res_nx;

	assign out_full  = (out_cnt_q == 2'd2);
	assign in_pop    = !in_empty && !out_full;
	assign res_empty = (out_cnt_q == 2'd0);
	assign out_rd_en = res_pop && !res_empty;
	assign res       = out_mem_q[out_rd_q];

	// event decision for the word at the queue head
	always_comb begin
		logic [4:0]     c0;
		logic [4:0]     c1;
		logic [4:0]     down5;
		logic [4:0]     down2;
		logic [15:0]    ox;
		logic [15:0]    oy;
		tsec_pkg::event_t ev;
		c0    = tick_q[in_word.slot_idx];
		ox    = lx_q[in_word.slot_idx];
		oy    = ly_q[in_word.slot_idx];
		down5 = {1'b0, cfg.down_ticks};
		down2 = {cfg.down_ticks, 1'b0};
		c1    = (c0 == tsec_pkg::TICK_MAX) ? c0 : c0 + 5'd1;
		lx_nx = ox;
		ly_nx = oy;
		ev    = tsec_pkg::EV_NONE;
		if (!in_word.touch) begin
			if (c0 >= down5) begin
				ev = tsec_pkg::EV_UP;
			end
			tick_nx = '0;
		end else begin
			tick_nx = c1;
			if (c1 == down5) begin
				lx_nx = in_word.x;
				ly_nx = in_word.y;
				ev    = tsec_pkg::EV_DOWN;
			end else if (c1 > down5) begin
				// moved after the settle window
				if (((in_word.x != ox) || (in_word.y != oy)) && (c1 > down2)) begin
					lx_nx   = in_word.x;
					ly_nx   = in_word.y;
					ev      = tsec_pkg::EV_MOVE;
					tick_nx = down5;
				end
				// hold wins over move
				if (tick_nx == cfg.hold_ticks) begin
					lx_nx = in_word.x;
					ly_nx = in_word.y;
					ev    = tsec_pkg::EV_HOLD;
				end
				if (tick_nx > cfg.hold_ticks) begin
					tick_nx = cfg.hold_ticks;
				end
			end
		end
		res_nx.slot = in_word.slot;
		if (in_word.slot_ok && (ev != tsec_pkg::EV_NONE)) begin
			res_nx.ev = ev;
			res_nx.x  = lx_nx;
			res_nx.y  = ly_nx;
		end else begin
			res_nx.ev = tsec_pkg::EV_NONE;
			res_nx.x  = '0;
			res_nx.y  = '0;
		end
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tsec_pkg::SLOTS; i++) begin
				tick_q[i] <= '0;
				lx_q[i]   <= '0;
				ly_q[i]   <= '0;
			end
		end else if (in_pop && in_word.slot_ok) begin
			tick_q[in_word.slot_idx] <= tick_nx;
			lx_q[in_word.slot_idx]   <= lx_nx;
			ly_q[in_word.slot_idx]   <= ly_nx;
		end
	end

	// two-entry result buffer
	always_ff @(posedge clk) begin
		if (in_pop) begin
			out_mem_q[out_wr_q] <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (in_pop) begin
				out_wr_q <= !out_wr_q;
			end
			if (out_rd_en) begin
				out_rd_q <= !out_rd_q;
			end
			case ({in_pop, out_rd_en})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	`TSEC_ASSERT(a_out_cnt_range, clk, arst_n, 1'b1, out_cnt_q <= 2'd2)
	`TSEC_ASSERT(a_none_zero_pos, clk, arst_n, !res_empty && (res.ev == tsec_pkg::EV_NONE), (res.x == 16'd0) && (res.y == 16'd0))
	`TSEC_ASSERT_NEXT(a_bad_slot_none, clk, arst_n, in_pop && !in_word.slot_ok && res_empty, res.ev == tsec_pkg::EV_NONE)

endmodule

[hdl/touch_slot_event_classifier.sv]
// ----------------------------------------------------------------------------
// touch_slot_event_classifier
// turns per-slot touch polls into down, move, hold and up events
// ----------------------------------------------------------------------------
// usage:
//   input channel: drive slot, present, raw_x, raw_y and raise push; the word
//   is taken on a clock edge with push high and full low
//   result channel: while empty is low the oldest result sits on out_slot,
//   event_res, pos_x, pos_y; raising pop takes it on that edge
//   every input word gives exactly one result word, in input order
//   config channel: cfg_index picks the register (max_x, max_y, mirror_x,
//   mirror_y, down_ticks, hold_ticks), cfg_data carries the value; cfg_ready
//   is always high, write only while the block is idle
//   path: a word taken into the queue passes the event logic and is written
//   into the result buffer, from where it shows on the result ports
//   throughput: one word per cycle while the result buffer is not full, set
//   by the per-slot read-modify-write of counter and latched position
//   stalls: with pop held low the two-entry result buffer fills, then the
//   four-entry queue behind the front; full rises once both are occupied
//   reset: counters and latched positions clear to zero, queues empty,
//   registers return to 800, 480, 0, 0, 2, 20
// ----------------------------------------------------------------------------
module touch_slot_event_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// poll input
	input  logic        push,
	output logic        full,
	input  logic [2:0]  slot,
	input  logic        present,
	input  logic [15:0] raw_x,
	input  logic [15:0] raw_y,
	// event output
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  out_slot,
	output logic [2:0]  event_res,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tsec_pkg::cfg_t        cfg_q;
	tsec_pkg::front_word_t front_word;
	tsec_pkg::front_word_t mid_word;
	logic                  mid_empty;
	logic                  mid_pop;
	tsec_pkg::res_t        res;

	// register file, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_x      <= tsec_pkg::MAX_X_RST;
			cfg_q.max_y      <= tsec_pkg::MAX_Y_RST;
			cfg_q.mirror_x   <= 1'b0;
			cfg_q.mirror_y   <= 1'b0;
			cfg_q.down_ticks <= tsec_pkg::DOWN_TICKS_RST;
			cfg_q.hold_ticks <= tsec_pkg::HOLD_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsec_pkg::CFG_MAX_X:      cfg_q.max_x      <= cfg_data;
				tsec_pkg::CFG_MAX_Y:      cfg_q.max_y      <= cfg_data;
				tsec_pkg::CFG_MIRROR_X:   cfg_q.mirror_x   <= cfg_data[0];
				tsec_pkg::CFG_MIRROR_Y:   cfg_q.mirror_y   <= cfg_data[0];
				tsec_pkg::CFG_DOWN_TICKS: cfg_q.down_ticks <= cfg_data[3:0];
				tsec_pkg::CFG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// front: mirror and range check
	tsec_front u_front (
		.cfg     (cfg_q),
		.slot    (slot),
		.present (present),
		.raw_x   (raw_x),
		.raw_y   (raw_y),
		.word    (front_word)
	);

	// decoupling queue
	tsec_fifo u_midq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_word),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_word),
		.empty  (mid_empty)
	);

	// back: slot state and event decision
	tsec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_empty  (mid_empty),
		.in_word   (mid_word),
		.in_pop    (mid_pop),
		.res_empty (empty),
		.res_pop   (pop),
		.res       (res)
	);

	assign out_slot  = res.slot;
	assign event_res = res.ev;
	assign pos_x     = res.x;
	assign pos_y     = res.y;

endmodule
